// File: rtl/spdm_pkg.sv
`timescale 1ns / 1ps

package spdm_pkg;

    // Depth of the source history and the derived index widths.
    localparam int unsigned HISTORY_DEPTH = 50;
    localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int unsigned HIST_LAST     = HISTORY_DEPTH - 1;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned GAIN_W   = 10;
    localparam int unsigned DELAY_W  = 6;

    // Width for delay and pointer arithmetic, wide enough for pointer plus depth.
    localparam int unsigned HIST_CW = ((HIST_AW > DELAY_W) ? HIST_AW : DELAY_W) + 1;

    localparam int unsigned NCH = 2;
    localparam int unsigned CH_LEFT  = 0;
    localparam int unsigned CH_RIGHT = 1;

    localparam int unsigned GAIN_SHIFT = 8;
    localparam int          GAIN_ONE   = 256;
    localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int unsigned SCALED_W   = PROD_W - GAIN_SHIFT;
    localparam int unsigned SUM_W      = SCALED_W + 1;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(GAIN_ONE);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(49);

    // Configuration register indexes.
    localparam int unsigned          REG_IDX_W        = 2;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_GAIN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_GAIN   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_LEFT   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_RIGHT  = 2'd3;
    localparam int unsigned          PADDR_W          = REG_IDX_W + 2;
    localparam int unsigned          PDATA_W          = 32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] source_left;
        logic signed [SAMPLE_W-1:0] source_right;
        logic signed [SAMPLE_W-1:0] bus_left;
        logic signed [SAMPLE_W-1:0] bus_right;
        logic                       end_of_block;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mix_left;
        logic signed [SAMPLE_W-1:0] mix_right;
        logic                       end_of_block_out;
    } t_out_item;

    // Division by 256 with truncation toward zero.
    function automatic logic signed [SCALED_W-1:0] f_div256(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] biased;
        biased = p[PROD_W-1] ? (p + $signed(PROD_W'(GAIN_ONE - 1))) : p;
        return SCALED_W'(biased >>> GAIN_SHIFT);
    endfunction

    // Saturation to a signed 16-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] f_sat16(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SAMPLE_W-1:0] res;
        if (s > $signed(SUM_W'(SAT_MAX))) begin
            res = SAMPLE_W'(SAT_MAX);
        end else if (s < $signed(SUM_W'(SAT_MIN))) begin
            res = SAMPLE_W'(SAT_MIN);
        end else begin
            res = SAMPLE_W'(s);
        end
        return res;
    endfunction

endpackage

// File: rtl/spdm_if.sv
`timescale 1ns / 1ps

// Input channel: one source pair and one bus pair per transfer.
interface spdm_in_if;
    import spdm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Output channel: one mixed pair per transfer.
interface spdm_out_if;
    import spdm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/stereo_pan_delay_mixer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// i_src     in         valid / ready      source_left, source_right, bus_left,
//                                         bus_right, end_of_block
// o_mix     out        valid / ready      mix_left, mix_right, end_of_block_out
// APB       in         psel/penable/...   gain and delay for each channel
//
// One transfer is accepted every cycle while the output side keeps up; each
// input transfer gives exactly one output transfer. Data passes through the
// registered read of the history RAMs, the gain multiplier register and the
// output register, one stage each.
// Reset (synchronous, active low) clears the pipeline, the write pointer and
// the fill count and loads the register defaults; no clearing pass is needed.
// A stall on the output propagates back stage by stage, so empty stages still
// take new transfers while a finished result waits.

module stereo_pan_delay_mixer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    spdm_in_if.sink                          i_src,
    spdm_out_if.source                       o_mix,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spdm_pkg::PADDR_W-1:0]     paddr,
    input  logic [spdm_pkg::PDATA_W-1:0]     pwdata,
    output logic [spdm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    import spdm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land in the access phase; the
    // register index is taken from the word address.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]    r_left_gain;
    logic [GAIN_W-1:0]    r_right_gain;
    logic [DELAY_W-1:0]   r_delay_left;
    logic [DELAY_W-1:0]   r_delay_right;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_gain   <= GAIN_RESET;
            r_right_gain  <= GAIN_RESET;
            r_delay_left  <= DELAY_RESET;
            r_delay_right <= DELAY_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LEFT_GAIN:   r_left_gain   <= pwdata[GAIN_W-1:0];
                REG_RIGHT_GAIN:  r_right_gain  <= pwdata[GAIN_W-1:0];
                REG_DELAY_LEFT:  r_delay_left  <= pwdata[DELAY_W-1:0];
                REG_DELAY_RIGHT: r_delay_right <= pwdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LEFT_GAIN:   prdata = PDATA_W'(r_left_gain);
            REG_RIGHT_GAIN:  prdata = PDATA_W'(r_right_gain);
            REG_DELAY_LEFT:  prdata = PDATA_W'(r_delay_left);
            REG_DELAY_RIGHT: prdata = PDATA_W'(r_delay_right);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage takes new data when it is empty
    // or when the stage after it moves on.
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_vo;
    logic rdy1;
    logic rdy2;
    logic rdy_o;
    logic in_acc;

    assign rdy_o       = !r_vo || o_mix.ready;
    assign rdy2        = !r_v2 || rdy_o;
    assign rdy1        = !r_v1 || rdy2;
    assign i_src.ready = rdy1;
    assign in_acc      = i_src.valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_src.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // History write pointer and fill count. The pointer moves to the next
    // slot before the new pair is stored, so it always marks the newest
    // pair. The fill count tells which older slots have never been written
    // since reset; those read as zero.
    // ------------------------------------------------------------------
    logic [HIST_AW-1:0] r_wpos;
    logic [HIST_AW-1:0] n_wpos;
    logic [HIST_AW-1:0] r_fill;

    assign n_wpos = (r_wpos == HIST_AW'(HIST_LAST)) ? '0 : (r_wpos + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
        end else if (in_acc) begin
            r_wpos <= n_wpos;
            if (r_fill != HIST_AW'(HIST_LAST)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read address per channel. A delay beyond the last slot is clamped,
    // so the newest pair is read. A look-back of zero means the pair that
    // arrives in this very transfer, which is taken from the input register
    // rather than from the RAM.
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0]         delay   [NCH];
    logic [GAIN_W-1:0]          gain    [NCH];
    logic signed [SAMPLE_W-1:0] src_in  [NCH];
    logic signed [SAMPLE_W-1:0] bus_in  [NCH];
    logic [HIST_AW-1:0]         rd_addr [NCH];
    logic [NCH-1:0]             back_zero;
    logic [NCH-1:0]             back_unwritten;

    always_comb begin
        logic [HIST_CW-1:0] d_ext;
        logic [HIST_CW-1:0] d_clamp;
        logic [HIST_CW-1:0] back;
        logic [HIST_CW-1:0] wp_ext;
        logic [HIST_CW-1:0] addr_ext;

        delay[CH_LEFT]  = r_delay_left;
        delay[CH_RIGHT] = r_delay_right;
        gain[CH_LEFT]   = r_left_gain;
        gain[CH_RIGHT]  = r_right_gain;
        src_in[CH_LEFT]  = i_src.data.source_left;
        src_in[CH_RIGHT] = i_src.data.source_right;
        bus_in[CH_LEFT]  = i_src.data.bus_left;
        bus_in[CH_RIGHT] = i_src.data.bus_right;

        wp_ext = HIST_CW'(n_wpos);
        for (int ch = 0; ch < NCH; ch++) begin
            d_ext   = HIST_CW'(delay[ch]);
            d_clamp = (d_ext > HIST_CW'(HIST_LAST)) ? HIST_CW'(HIST_LAST) : d_ext;
            back    = HIST_CW'(HIST_LAST) - d_clamp;
            if (wp_ext >= back) begin
                addr_ext = wp_ext - back;
            end else begin
                addr_ext = wp_ext + HIST_CW'(HISTORY_DEPTH) - back;
            end
            rd_addr[ch]        = addr_ext[HIST_AW-1:0];
            back_zero[ch]      = (back == '0);
            back_unwritten[ch] = (back > HIST_CW'(r_fill));
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: history RAM read, input pair and flags registered.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] ram_q [NCH];
    logic signed [SAMPLE_W-1:0] r1_src [NCH];
    logic signed [SAMPLE_W-1:0] r1_bus [NCH];
    logic                       r1_eob;
    logic [NCH-1:0]             r1_cur;
    logic [NCH-1:0]             r1_zero;

    for (genvar ch = 0; ch < NCH; ch++) begin : g_hist
        spdm_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (HISTORY_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (in_acc),
            .i_wr_addr (n_wpos),
            .i_wr_data (src_in[ch]),
            .i_rd_en   (in_acc),
            .i_rd_addr (rd_addr[ch]),
            .o_rd_data (ram_q[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_src  <= src_in;
            r1_bus  <= bus_in;
            r1_eob  <= i_src.data.end_of_block;
            r1_cur  <= back_zero;
            r1_zero <= back_unwritten;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the delayed sample and multiply by the channel gain.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]   prod   [NCH];
    logic signed [PROD_W-1:0]   r2_prod [NCH];
    logic signed [SAMPLE_W-1:0] r2_bus  [NCH];
    logic                       r2_eob;

    always_comb begin
        logic signed [SAMPLE_W-1:0] smp;
        for (int ch = 0; ch < NCH; ch++) begin
            if (r1_cur[ch]) begin
                smp = r1_src[ch];
            end else if (r1_zero[ch]) begin
                smp = '0;
            end else begin
                smp = ram_q[ch];
            end
            prod[ch] = smp * $signed({1'b0, gain[ch]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r2_prod <= prod;
            r2_bus  <= r1_bus;
            r2_eob  <= r1_eob;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: scale down, add the bus sample and saturate.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] mix [NCH];
    t_out_item                  r_out;

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        for (int ch = 0; ch < NCH; ch++) begin
            sum     = SUM_W'(r2_bus[ch]) + SUM_W'(f_div256(r2_prod[ch]));
            mix[ch] = f_sat16(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy_o) begin
            r_out.mix_left         <= mix[CH_LEFT];
            r_out.mix_right        <= mix[CH_RIGHT];
            r_out.end_of_block_out <= r2_eob;
        end
    end

    assign o_mix.valid = r_vo;
    assign o_mix.data  = r_out;

`ifndef SYNTH
    // The write pointer stays within the history.
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= HIST_AW'(HIST_LAST))
        else $error("history write pointer out of range");

    // A full pipeline with a stalled output must refuse new transfers.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_vo && !o_mix.ready) |-> !i_src.ready)
        else $error("input accepted while every stage is blocked");

    // An accepted transfer always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_v1)
        else $error("accepted transfer lost from first stage");

    // Once the history is full no read may be forced to zero.
    a_no_zero_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_fill == HIST_AW'(HIST_LAST)) |=> (r1_zero == '0))
        else $error("unwritten history reported after fill");
`endif

endmodule

// File: rtl/spdm_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read port.
module spdm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/spdm_checker.sv
`timescale 1ns / 1ps

module spdm_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spdm_in_if                           i_src_mon,
    spdm_out_if                          i_mix_mon,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [spdm_pkg::PADDR_W-1:0] i_paddr,
    input  logic [spdm_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [spdm_pkg::PDATA_W-1:0] i_prdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    import spdm_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic signed [SAMPLE_W-1:0] left_history  [0:HISTORY_DEPTH-1];
    logic signed [SAMPLE_W-1:0] right_history [0:HISTORY_DEPTH-1];
    int unsigned                newest;
    logic [GAIN_W-1:0]          gain_left;
    logic [GAIN_W-1:0]          gain_right;
    logic [DELAY_W-1:0]         delay_left;
    logic [DELAY_W-1:0]         delay_right;
    t_out_item                  mix_expected [$];
    int                         failures;
    int                         compared;

    initial begin
        failures     = 0;
        compared     = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Scale by the gain, divide by 256 toward zero, add the bus and clamp.
    function automatic logic signed [SAMPLE_W-1:0] mix_channel(
        input logic signed [SAMPLE_W-1:0] bus,
        input logic signed [SAMPLE_W-1:0] src,
        input logic [GAIN_W-1:0]          gain
    );
        int scaled;
        int sum;
        scaled = (int'(src) * int'({1'b0, gain})) / GAIN_ONE;
        sum    = int'(bus) + scaled;
        if (sum > SAT_MAX) begin
            sum = SAT_MAX;
        end else if (sum < SAT_MIN) begin
            sum = SAT_MIN;
        end
        return SAMPLE_W'(sum);
    endfunction

    // A delay of HIST_LAST or more reads the newest pair; smaller ones reach back.
    function automatic int unsigned tap_index(input logic [DELAY_W-1:0] delay);
        int unsigned d;
        int unsigned back;
        d    = (int'(delay) > HIST_LAST) ? HIST_LAST : int'(delay);
        back = HIST_LAST - d;
        return (newest + HISTORY_DEPTH - back) % HISTORY_DEPTH;
    endfunction

    function automatic logic [PDATA_W-1:0] register_value(input logic [REG_IDX_W-1:0] index);
        logic [PDATA_W-1:0] value;
        case (index)
            REG_LEFT_GAIN:   value = PDATA_W'(gain_left);
            REG_RIGHT_GAIN:  value = PDATA_W'(gain_right);
            REG_DELAY_LEFT:  value = PDATA_W'(delay_left);
            default:         value = PDATA_W'(delay_right);
        endcase
        return value;
    endfunction

    always @(posedge i_clk) begin
        t_out_item          got;
        t_out_item          want;
        logic [PDATA_W-1:0] reg_now;
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                left_history[k]  = '0;
                right_history[k] = '0;
            end
            newest      = 0;
            gain_left   = GAIN_RESET;
            gain_right  = GAIN_RESET;
            delay_left  = DELAY_RESET;
            delay_right = DELAY_RESET;
            mix_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[PADDR_W-1:2])
                        REG_LEFT_GAIN:   gain_left   = i_pwdata[GAIN_W-1:0];
                        REG_RIGHT_GAIN:  gain_right  = i_pwdata[GAIN_W-1:0];
                        REG_DELAY_LEFT:  delay_left  = i_pwdata[DELAY_W-1:0];
                        REG_DELAY_RIGHT: delay_right = i_pwdata[DELAY_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_now = register_value(i_paddr[PADDR_W-1:2]);
                    if (i_prdata !== reg_now) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("register read at 0x%0h: expected 0x%0h, got 0x%0h",
                                     i_paddr, reg_now, i_prdata);
                        end
                    end
                end
            end

            if (i_mix_mon.valid && i_mix_mon.ready) begin
                got = i_mix_mon.data;
                if (mix_expected.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("mix transfer with nothing expected: L=%0d R=%0d eob=%0b",
                                 got.mix_left, got.mix_right, got.end_of_block_out);
                    end
                end else begin
                    want = mix_expected.pop_front();
                    compared++;
                    if (got.mix_left !== want.mix_left || got.mix_right !== want.mix_right
                            || got.end_of_block_out !== want.end_of_block_out) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("mix %0d: expected L=%0d R=%0d eob=%0b",
                                     compared, want.mix_left, want.mix_right,
                                     want.end_of_block_out);
                            $display("        got L=%0d R=%0d eob=%0b",
                                     got.mix_left, got.mix_right, got.end_of_block_out);
                        end
                    end
                end
            end

            if (i_src_mon.valid && i_src_mon.ready) begin
                newest                = (newest + 1) % HISTORY_DEPTH;
                left_history[newest]  = i_src_mon.data.source_left;
                right_history[newest] = i_src_mon.data.source_right;
                want.mix_left  = mix_channel(i_src_mon.data.bus_left,
                                             left_history[tap_index(delay_left)], gain_left);
                want.mix_right = mix_channel(i_src_mon.data.bus_right,
                                             right_history[tap_index(delay_right)], gain_right);
                want.end_of_block_out = i_src_mon.data.end_of_block;
                mix_expected.insert(mix_expected.size(), want);
            end
        end
        o_pending    <= mix_expected.size();
        o_fail_count <= failures;
        o_checked    <= compared;
    end

endmodule

// File: tb/tb_stereo_pan_delay_mixer.sv
`timescale 1ns / 1ps

// The top level only makes stimulus and gives the verdict. All prediction and
// comparison live in the checker, which watches both channels and the register
// port and hands back its failure count and the number of results outstanding.
module tb_stereo_pan_delay_mixer;
    import spdm_pkg::*;

    localparam int IDLE_PERCENT    = 35;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    spdm_in_if  src_ch ();
    spdm_out_if mix_ch ();

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int sent        = 0;
    int settings    = 0;

    // When no_idle is set neither side inserts gaps. A hold request makes the
    // receiver refuse transfers for a hold-off whose length HOLD_CYCLES gives, counted by itself.
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    stereo_pan_delay_mixer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_ch),
        .o_mix   (mix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spdm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src_mon    (src_ch),
        .i_mix_mon    (mix_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: a run that stalls or loses a result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver. Each pass through the loop makes exactly one assignment to
    // ready in the current time step, so a hold-off never clashes with the
    // random choice.
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            hold_request = 1'b0;
            mix_ch.ready <= 1'b0;
            for (int held = 1; held < HOLD_CYCLES; held++) begin
                @(posedge i_clk);
            end
        end else begin
            mix_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Random samples lean on the rails and on small values, where truncation
    // and saturation show up, but most are spread over the full 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] value;
        case ($urandom_range(9))
            0:       value = SAMPLE_W'(SAT_MAX);
            1:       value = SAMPLE_W'(SAT_MIN);
            2, 3:    value = SAMPLE_W'(int'($urandom_range(1023)) - 512);
            default: value = SAMPLE_W'($urandom());
        endcase
        return value;
    endfunction

    function automatic t_in_item random_mix_item();
        t_in_item item;
        item.source_left  = pick_sample();
        item.source_right = pick_sample();
        item.bus_left     = pick_sample();
        item.bus_right    = pick_sample();
        item.end_of_block = ($urandom_range(7) == 0);
        return item;
    endfunction

    // The bits above a register's width are filled with noise, which the
    // block must discard.
    function automatic logic [PDATA_W-1:0] with_noise(input int unsigned value, input int width);
        return ($urandom() << width) | PDATA_W'(value);
    endfunction

    // Offers one item and returns in the time step at which it was taken.
    // The gap loop and the final offer each make one assignment per step, so
    // valid is never lowered and raised again within the same step.
    task automatic offer_item(input t_in_item item);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                src_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        src_ch.valid <= 1'b1;
        src_ch.data  <= item;
        do @(posedge i_clk); while (!src_ch.ready);
        sent++;
    endtask

    task automatic offer_fields(input int src_l, input int src_r, input int bus_l,
                                input int bus_r, input bit eob);
        t_in_item item;
        item.source_left  = SAMPLE_W'(src_l);
        item.source_right = SAMPLE_W'(src_r);
        item.bus_left     = SAMPLE_W'(bus_l);
        item.bus_right    = SAMPLE_W'(bus_r);
        item.end_of_block = eob;
        offer_item(item);
    endtask

    // Stops offering and waits until every expected result has been
    // transferred, then lets the pipeline settle.
    task automatic wait_for_mix_results();
        src_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register writes take a setup and an access phase and then go idle,
    // so that back-to-back accesses never assign psel twice in one step.
    task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                  input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reads every register back; the checker compares the read data with
    // its own copy of the settings.
    task automatic read_registers();
        logic [REG_IDX_W-1:0] index;
        for (int k = 0; k < 4; k++) begin
            index   = REG_IDX_W'(k);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= PADDR_W'({index, 2'b00});
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_mix_config(input int unsigned gain_l, input int unsigned gain_r,
                                  input int unsigned delay_l, input int unsigned delay_r);
        write_register(REG_LEFT_GAIN,   with_noise(gain_l, GAIN_W));
        write_register(REG_RIGHT_GAIN,  with_noise(gain_r, GAIN_W));
        write_register(REG_DELAY_LEFT,  with_noise(delay_l, DELAY_W));
        write_register(REG_DELAY_RIGHT, with_noise(delay_r, DELAY_W));
        read_registers();
        settings++;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        src_ch.valid = 1'b0;
        src_ch.data  = '0;
        mix_ch.ready = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: unity gain on both sides and the newest sample read,
        // so each mix is simply bus plus source. The rails test saturation in
        // both directions and the end-of-block mark takes both values.
        read_registers();
        offer_fields(0, 0, 0, 0, 1'b0);
        offer_fields(32767, 32767, 32767, -32768, 1'b0);
        offer_fields(-32768, -32768, -32768, 32767, 1'b1);
        offer_fields(32767, -32768, 0, 0, 1'b1);
        offer_fields(4660, -4660, -32768, 32767, 1'b0);
        offer_fields(-1, 1, -1, 1, 1'b1);
        wait_for_mix_results();

        // Full-scale gain on the left with the oldest tap, which still lands
        // on the zeros left by reset since only a handful of pairs have gone
        // in. The right uses the smallest non-zero gain and a delay beyond the
        // history, which must fall back to the newest sample. The small
        // negative sources check that division truncates toward zero.
        set_mix_config(1023, 1, 0, 63);
        offer_fields(32767, 32767, 0, 0, 1'b0);
        offer_fields(-32768, -32768, 100, -100, 1'b1);
        offer_fields(0, -1, 0, 0, 1'b0);
        offer_fields(0, -255, 0, 0, 1'b0);
        offer_fields(0, -256, 0, 0, 1'b0);
        offer_fields(0, -257, 5, 5, 1'b1);
        offer_fields(0, 32767, 32767, 32767, 1'b0);
        wait_for_mix_results();

        // Muted left, so only the bus comes through there; the right reads one
        // pair back at full-scale gain and saturates both ways.
        set_mix_config(0, 1023, 49, 48);
        offer_fields(32767, 32767, -32768, 32767, 1'b0);
        offer_fields(-32768, -32768, 1, 1, 1'b1);
        offer_fields(-32768, 12345, 0, -32768, 0);
        offer_fields(1, -1, 0, 0, 1'b1);
        offer_fields(0, 0, 0, 0, 1'b0);
        wait_for_mix_results();

        // Random phases, each under its own setting. The first two pin the
        // extremes; the rest draw gains and delays across the whole field,
        // delays beyond the history included.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_mix_config(1023, 1023, 0, 0);
                1:       set_mix_config(0, 256, 49, 63);
                default: set_mix_config($urandom_range(1023), $urandom_range(1023),
                                        $urandom_range(63), $urandom_range(63));
            endcase

            // Phase two streams with no gaps on either side. Phase three also
            // streams, but the receiver first holds off for a long stretch so
            // that the pipeline fills and the input is pushed back.
            no_idle = (phase == 2) || (phase == 3);
            if (phase == 3) begin
                hold_request = 1'b1;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through phase five the sender pauses until the
                // pipeline has emptied completely.
                if (phase == 5 && n == ITEMS_PER_PHASE / 2) begin
                    wait_for_mix_results();
                end
                offer_item(random_mix_item());
            end
            wait_for_mix_results();
            no_idle = 1'b0;
        end

        $display("Covered %0d input transfers and %0d compared results over %0d settings,",
                 sent, checked, settings);
        $display("with rail values, truncation, saturation and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
